// ===== rtl/core/fas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_pkg
// Types and constants shared by the truncating single-precision adder.
// ----------------------------------------------------------------------------
package fas_pkg;

    localparam int FracBits = 23;
    localparam int ExpBits  = 8;

    typedef struct packed {
        logic        zero;
        logic        sign;
        logic        diff;
        logic [7:0]  ebig;
        logic [23:0] mbig;
        logic [23:0] msmall;
    } fas_align_t;

    typedef struct packed {
        logic        zero;
        logic        sign;
        logic [7:0]  ebig;
        logic [25:0] mc;
    } fas_sum_t;

endpackage

// ===== rtl/core/fas_align.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_align
// Stage one: orders the operands by magnitude and aligns the smaller mantissa.
// ----------------------------------------------------------------------------
module fas_align
(
    input  logic               operation,
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    output fas_pkg::fas_align_t result
);
    import fas_pkg::*;

    logic [31:0] b_eff;
    logic [31:0] big;
    logic [31:0] small_op;
    logic [7:0]  shift;
    logic [23:0] msmall_full;

    always_comb
    begin
        b_eff = {operand_b[31] ^ operation, operand_b[30:0]};
        if (b_eff[30:0] > operand_a[30:0])
        begin
            big      = b_eff;
            small_op = operand_a;
        end
        else
        begin
            big      = operand_a;
            small_op = b_eff;
        end
        shift       = big[30:23] - small_op[30:23];
        msmall_full = {1'b1, small_op[22:0]};
        result.zero = (big[31] != small_op[31]) && (big[30:0] == small_op[30:0]);
        result.sign = big[31];
        result.diff = big[31] != small_op[31];
        result.ebig = big[30:23];
        result.mbig = {1'b1, big[22:0]};
        result.msmall = (shift < 8'd24) ? (msmall_full >> shift[4:0]) : 24'd0;
    end

endmodule

// ===== rtl/core/fas_addsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_addsub
// Stage two: adds or subtracts the aligned mantissas.
// ----------------------------------------------------------------------------
module fas_addsub
(
    input  fas_pkg::fas_align_t operand,
    output fas_pkg::fas_sum_t   result
);
    import fas_pkg::*;

    always_comb
    begin
        result.zero = operand.zero;
        result.sign = operand.sign;
        result.ebig = operand.ebig;
        if (operand.diff)
        begin
            result.mc = {2'b00, operand.mbig} - {2'b00, operand.msmall};
        end
        else
        begin
            result.mc = {2'b00, operand.mbig} + {2'b00, operand.msmall};
        end
    end

endmodule

// ===== rtl/core/fas_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_norm
// Stage three: finds the leading one and normalizes the result.
// ----------------------------------------------------------------------------
module fas_norm
(
    input  fas_pkg::fas_sum_t operand,
    output logic [31:0]       sum_bits
);
    import fas_pkg::*;

    logic [4:0]  pos;
    logic [4:0]  d;
    logic [7:0]  exp_v;
    logic [8:0]  exp_sum;
    logic [25:0] mc_n;

    always_comb
    begin
        pos = 5'd0;
        for (int i = 1; i <= 25; i++)
        begin
            if (operand.mc[i])
            begin
                pos = 5'(i);
            end
        end
        d       = 5'd0;
        exp_v   = 8'd0;
        exp_sum = 9'd0;
        mc_n    = operand.mc;
        sum_bits = 32'd0;
        if (pos >= 5'd23)
        begin
            d        = pos - 5'd23;
            exp_sum  = {1'b0, operand.ebig} + {7'd0, d[1:0]};
            mc_n     = operand.mc >> d;
            sum_bits = {operand.sign | exp_sum[8], exp_sum[7:0], mc_n[22:0]};
        end
        else
        begin
            d     = 5'd23 - pos;
            exp_v = operand.ebig - {3'd0, d};
            mc_n  = operand.mc << d;
            if ({3'd0, d} < operand.ebig)
            begin
                sum_bits = {operand.sign, exp_v, mc_n[22:0]};
            end
        end
        if (operand.zero)
        begin
            sum_bits = 32'd0;
        end
    end

endmodule

// ===== rtl/core/float32_add_sub_truncating_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_add_sub_truncating_top
// Truncating single-precision adder and subtractor, three-stage pipeline.
// Each result is registered in s1_reg, s2_reg and s3_reg in turn.
// One transaction per cycle unless stalled; a stall holds only valid stages.
// Reset clears all stage valid bits asynchronously; payloads are not reset.
// ----------------------------------------------------------------------------
module float32_add_sub_truncating_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sum_bits
);
    import fas_pkg::*;

    fas_align_t s1_next, s1_reg;
    fas_sum_t   s2_next, s2_reg;
    logic [31:0] s3_next, s3_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;

    fas_align  u_align (.operation(operation), .operand_a(operand_a),
                        .operand_b(operand_b), .result(s1_next));
    fas_addsub u_addsub (.operand(s1_reg), .result(s2_next));
    fas_norm   u_norm (.operand(s2_reg), .sum_bits(s3_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign sum_bits  = s3_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the truncating single-precision adder and subtractor.
// Operand pairs are sent in random bursts while the result side stalls on its
// own pattern. Each result is compared with a sum predicted inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] sum_bits;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    logic [31:0] expected_sums[$];
    int          error_count = 0;
    int          burst_left = 0;
    int          stall_mode = 0;

    float32_add_sub_truncating_top dut (.*);

    always #1 clk = ~clk;

    function automatic logic [31:0] truncated_sum(logic op, logic [31:0] a, logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lesser;
        logic [7:0]  ebig;
        logic [7:0]  elesser;
        logic [31:0] shift;
        logic [31:0] mbig;
        logic [31:0] mlesser;
        logic [31:0] mc;
        logic [31:0] expo;
        int          lead;
        int          d;
        if (op == OP_SUB)
            b[31] = ~b[31];
        big = a;
        lesser = b;
        if (b[30:0] > a[30:0])
        begin
            big = b;
            lesser = a;
        end
        if (big[31] != lesser[31] && a[30:0] == b[30:0])
            return 32'd0;
        ebig = big[30:23];
        elesser = lesser[30:23];
        shift = 32'(ebig) - 32'(elesser);
        mbig = {9'd1, big[22:0]};
        mlesser = {9'd1, lesser[22:0]};
        mlesser = (shift < 32) ? (mlesser >> shift) : 32'd0;
        mc = (big[31] != lesser[31]) ? mbig - mlesser : mbig + mlesser;
        lead = 25;
        while (lead > 0 && mc[lead] == 1'b0)
            lead--;
        if (lead >= fas_pkg::FracBits)
        begin
            d = lead - fas_pkg::FracBits;
            expo = 32'(ebig) + 32'(d);
            mc = mc >> d;
        end
        else
        begin
            d = fas_pkg::FracBits - lead;
            if (d >= ebig)
                return 32'd0;
            expo = 32'(ebig) - 32'(d);
            mc = mc << d;
        end
        return ({big[31], 31'd0}) | (expo << 23) | {9'd0, mc[22:0]};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("error: %s got %h expected %h", what, got, want);
        error_count++;
    endtask

    task automatic send_sum(logic op, logic [31:0] a, logic [31:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (!in_ready);
        expected_sums.push_back(truncated_sum(op, a, b));
        burst_left--;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
                report_mismatch("unexpected transaction", sum_bits, 32'd0);
            else
            begin
                logic [31:0] want;
                want = expected_sums.pop_front();
                if (sum_bits !== want)
                    report_mismatch("sum_bits", sum_bits, want);
            end
        end
        if ($urandom_range(0, 199) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'd0;
            1: v[30:23] = 8'hFF;
            2: v[30:23] = 8'($urandom_range(1, 4));
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_sum(OP_ADD, 32'h0000_0000, 32'h0000_0000);
        send_sum(OP_SUB, 32'h0000_0000, 32'h0000_0000);
        send_sum(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sum(OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sum(OP_ADD, 32'h3F80_0000, 32'hBF80_0000);
        send_sum(OP_SUB, 32'h4049_0FDB, 32'h4049_0FDB);
        send_sum(OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_sum(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sum(OP_ADD, 32'h4F00_0000, 32'h0000_0001);
        send_sum(OP_ADD, 32'h5000_0000, 32'h3F80_0000);
        send_sum(OP_SUB, 32'h0080_0001, 32'h0080_0000);
        send_sum(OP_SUB, 32'h0100_0000, 32'h00FF_FFFF);
        send_sum(OP_SUB, 32'h3F80_0001, 32'h3F80_0000);
        send_sum(OP_ADD, 32'h8000_0001, 32'h0000_0002);
        send_sum(OP_SUB, 32'h0000_0003, 32'h0000_0001);
        send_sum(OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
        send_sum(OP_SUB, 32'h5555_5555, 32'hAAAA_AAAA);
        send_sum(OP_ADD, 32'hC000_0000, 32'h3F7F_FFFF);
    endtask

    task automatic test_drain_pause();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_random(int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = random_operand();
            b = random_operand();
            case ($urandom_range(0, 4))
                0: b = a ^ {$urandom_range(0, 1) == 1, 31'd0};
                1: b[30:23] = 8'(a[30:23] + $urandom_range(0, 2) - 1);
                default: ;
            endcase
            send_sum(1'($urandom_range(0, 1)), a, b);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_random(500);
        test_drain_pause();
        test_random(500);
        in_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
